// ===== rtl/tsu_pkg.sv =====
// Shared types, constants and helpers for the timer sampled UART.
`default_nettype none
package tsu_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int TIMER_W    = 16;
  localparam int FRAME_BITS = 10;
  localparam int DATA_BITS  = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic REG_BIT_TICKS    = 1'b0;
  localparam logic REG_FIRST_SAMPLE = 1'b1;

  localparam logic [TIMER_W-1:0] BIT_TICKS_RESET    = 16'd1667;
  localparam logic [TIMER_W-1:0] FIRST_SAMPLE_RESET = 16'd2500;

  typedef struct packed {
    logic line;
    logic busy;
    logic refused;
  } tx_status_t;

  typedef struct packed {
    logic                 valid;
    logic [DATA_BITS-1:0] data;
  } rx_push_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 read_empty;
    logic [FIFO_CW-1:0]   count;
  } fifo_status_t;

  // A zero period behaves as one tick.
  function automatic logic [TIMER_W-1:0] period_of(input logic [TIMER_W-1:0] v);
    period_of = (v == '0) ? TIMER_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tsu_tx.sv =====
// Transmit shifter: frame load on write, one bit out per bit period on ticks.
`default_nettype none
module tsu_tx
  import tsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           operation,
  input  logic [DATA_BITS-1:0] tx_byte,
  input  logic [TIMER_W-1:0]   bit_ticks,
  output tx_status_t           status
);

  logic [FRAME_BITS-1:0] shift, shift_next;
  logic [3:0]            bits_left, bits_left_next;
  logic [TIMER_W-1:0]    timer, timer_next;
  logic                  level, level_next;
  logic                  refused;

  always_comb begin
    shift_next     = shift;
    bits_left_next = bits_left;
    timer_next     = timer;
    level_next     = level;
    refused        = 1'b0;
    if (accept) begin
      unique case (operation)
        OP_TICK: begin
          if (bits_left != '0) begin
            if (timer > TIMER_W'(1)) begin
              timer_next = timer - TIMER_W'(1);
            end else begin
              level_next     = shift[0];
              shift_next     = {1'b0, shift[FRAME_BITS-1:1]};
              bits_left_next = bits_left - 4'd1;
              timer_next     = period_of(bit_ticks);
            end
          end
        end
        OP_WRITE: begin
          if (bits_left != '0) begin
            refused = 1'b1;
          end else begin
            shift_next     = {1'b1, tx_byte, 1'b0};
            bits_left_next = 4'(FRAME_BITS);
            timer_next     = period_of(bit_ticks);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift     <= '0;
      bits_left <= '0;
      timer     <= '0;
      level     <= 1'b1;
    end else begin
      shift     <= shift_next;
      bits_left <= bits_left_next;
      timer     <= timer_next;
      level     <= level_next;
    end
  end

  assign status.line    = level_next;
  assign status.busy    = (bits_left_next != '0);
  assign status.refused = refused;

endmodule
`default_nettype wire

// ===== rtl/tsu_rx.sv =====
// Receive sampler: start edge hunt, timed data bit sampling, byte hand-off.
`default_nettype none
module tsu_rx
  import tsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         operation,
  input  logic               rx_line,
  input  logic [TIMER_W-1:0] bit_ticks,
  input  logic [TIMER_W-1:0] first_sample_ticks,
  output rx_push_t           push
);

  logic                 hunting, hunting_next;
  logic                 prev_level, prev_level_next;
  logic [TIMER_W-1:0]   timer, timer_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [3:0]           bit_index, bit_index_next;

  always_comb begin
    hunting_next    = hunting;
    prev_level_next = prev_level;
    timer_next      = timer;
    shift_next      = shift;
    bit_index_next  = bit_index;
    push.valid      = 1'b0;
    push.data       = shift;
    if (accept && (operation == OP_TICK)) begin
      if (hunting) begin
        if (prev_level && !rx_line) begin
          hunting_next   = 1'b0;
          timer_next     = period_of(first_sample_ticks);
          bit_index_next = '0;
          shift_next     = '0;
        end
      end else if (timer > TIMER_W'(1)) begin
        timer_next = timer - TIMER_W'(1);
      end else begin
        // sample index stays below eight while receiving
        shift_next     = shift | (DATA_BITS'(rx_line) << bit_index[2:0]);
        bit_index_next = bit_index + 4'd1;
        timer_next     = period_of(bit_ticks);
        if (bit_index_next >= 4'(DATA_BITS)) begin
          hunting_next = 1'b1;
          push.valid   = 1'b1;
        end
      end
      push.data       = shift_next;
      prev_level_next = rx_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting    <= 1'b1;
      prev_level <= 1'b1;
      timer      <= '0;
      shift      <= '0;
      bit_index  <= '0;
    end else begin
      hunting    <= hunting_next;
      prev_level <= prev_level_next;
      timer      <= timer_next;
      shift      <= shift_next;
      bit_index  <= bit_index_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tsu_fifo.sv =====
// Receive FIFO: register array with head, tail and fill count.
`default_nettype none
module tsu_fifo
  import tsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [1:0]   operation,
  input  rx_push_t     push,
  output fifo_status_t status
);

  logic [DATA_BITS-1:0] mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head, head_next;
  logic [FIFO_AW-1:0]   tail, tail_next;
  logic [FIFO_CW-1:0]   count, count_next;
  logic                 do_write;
  logic                 do_read;

  assign do_write = push.valid && (count < FIFO_CW'(FIFO_DEPTH));
  assign do_read  = accept && (operation == OP_READ) && (count != '0);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (do_write) begin
      head_next  = (head == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head + FIFO_AW'(1);
      count_next = count + FIFO_CW'(1);
    end
    if (do_read) begin
      tail_next  = (tail == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail + FIFO_AW'(1);
      count_next = count - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[head] <= push.data;
    end
  end

  assign status.read_data  = do_read ? mem[tail] : '0;
  assign status.read_empty = accept && (operation == OP_READ) && (count == '0);
  assign status.count      = count_next;

endmodule
`default_nettype wire

// ===== rtl/timer_sampled_uart_with_rx_fifo_top.sv =====
// UART 8N1 transceiver driven by timer ticks, with a 16-entry receive FIFO.
// Each input transfer is a timer tick, a transmit byte write or a receive
// byte read; one is accepted every clock cycle while in_stall is low and
// its result appears in the output register on the next cycle, so the
// sustained rate is one item per cycle when nothing stalls. The path is
// one pass of timer, shifter and FIFO pointer logic between the state
// registers and the output register. in_stall rises only while a result
// sits in the output register and out_stall holds it. The user is to
// write bit_ticks (address 0) and first_sample_ticks (address 4) over the
// APB port only while idle, not enforced by the block; zero acts as one.
`default_nettype none
module timer_sampled_uart_with_rx_fifo_top
  import tsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [DATA_BITS-1:0] tx_byte,
  input  logic                 rx_line,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 tx_line,
  output logic                 tx_busy,
  output logic                 write_refused,
  output logic [DATA_BITS-1:0] read_data,
  output logic                 read_empty,
  output logic [FIFO_CW-1:0]   rx_available
);

  logic [TIMER_W-1:0] bit_ticks;
  logic [TIMER_W-1:0] first_sample_ticks;
  logic               cfg_write;
  logic               accept;
  tx_status_t         tx_status;
  rx_push_t           rx_push;
  fifo_status_t       fifo_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks          <= BIT_TICKS_RESET;
      first_sample_ticks <= FIRST_SAMPLE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BIT_TICKS) begin
        bit_ticks <= pwdata[TIMER_W-1:0];
      end else begin
        first_sample_ticks <= pwdata[TIMER_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FIRST_SAMPLE) begin
      prdata = {16'b0, first_sample_ticks};
    end else begin
      prdata = {16'b0, bit_ticks};
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  tsu_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .tx_byte   (tx_byte),
    .bit_ticks (bit_ticks),
    .status    (tx_status)
  );

  tsu_rx u_rx (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .operation          (operation),
    .rx_line            (rx_line),
    .bit_ticks          (bit_ticks),
    .first_sample_ticks (first_sample_ticks),
    .push               (rx_push)
  );

  tsu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .push      (rx_push),
    .status    (fifo_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (accept) begin
      tx_line       <= tx_status.line;
      tx_busy       <= tx_status.busy;
      write_refused <= tx_status.refused;
      read_data     <= fifo_status.read_data;
      read_empty    <= fifo_status.read_empty;
      rx_available  <= fifo_status.count;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rx_available <= FIFO_CW'(FIFO_DEPTH)))
    else $error("receive FIFO fill count above depth");

  a_refused_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_refused) |-> tx_busy)
    else $error("write refused while transmitter idle");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_empty) |-> ((read_data == '0) && (rx_available == '0)))
    else $error("empty read with data or nonzero fill");

  a_tick_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_TICK)) |=> (!write_refused && !read_empty))
    else $error("tick produced a write or read flag");
`endif

endmodule
`default_nettype wire

// ===== bench/timer_sampled_uart_with_rx_fifo_top_tb.sv =====
// Self-checking bench for the timer sampled UART transceiver and its receive FIFO.
`default_nettype none
module timer_sampled_uart_with_rx_fifo_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                 tx_line;
    logic                 tx_busy;
    logic                 write_refused;
    logic [DATA_BITS-1:0] read_data;
    logic                 read_empty;
    logic [FIFO_CW-1:0]   rx_available;
  } uart_status_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid, in_stall;
  logic [1:0]           operation;
  logic [DATA_BITS-1:0] tx_byte;
  logic                 rx_line;
  logic                 out_valid, out_stall;
  logic                 tx_line, tx_busy, write_refused;
  logic [DATA_BITS-1:0] read_data;
  logic                 read_empty;
  logic [FIFO_CW-1:0]   rx_available;

  // effective periods, zero already turned into one
  logic [TIMER_W-1:0]    bit_period, first_sample_period;
  logic [FRAME_BITS-1:0] tx_frame;
  logic [3:0]            tx_left;
  logic [TIMER_W-1:0]    tx_count;
  logic                  tx_level;
  logic                  rx_hunt, rx_prev;
  logic [TIMER_W-1:0]    rx_count;
  logic [DATA_BITS-1:0]  rx_shift;
  logic [3:0]            rx_index;
  logic [DATA_BITS-1:0]  received_bytes[$];

  uart_status_t awaited_status[$];
  int  items_sent = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  idle_pct = 29;
  int  stall_pct = 29;
  int  hold_left = 0;
  bit  hold_request = 1'b0;

  timer_sampled_uart_with_rx_fifo_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .tx_byte      (tx_byte),
    .rx_line      (rx_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_line      (tx_line),
    .tx_busy      (tx_busy),
    .write_refused(write_refused),
    .read_data    (read_data),
    .read_empty   (read_empty),
    .rx_available (rx_available)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_uart_state();
    bit_period = BIT_TICKS_RESET;
    first_sample_period = FIRST_SAMPLE_RESET;
    tx_frame = '0;
    tx_left = '0;
    tx_count = '0;
    tx_level = 1'b1;
    rx_hunt = 1'b1;
    rx_prev = 1'b1;
    rx_count = '0;
    rx_shift = '0;
    rx_index = '0;
    received_bytes.delete();
  endtask

  function automatic uart_status_t advance_uart(logic [1:0] op, logic [DATA_BITS-1:0] data,
                                                logic line);
    uart_status_t s;
    s = '0;
    case (op)
      OP_TICK: begin
        if (tx_left != 0) begin
          if (tx_count > 1) begin
            tx_count = tx_count - TIMER_W'(1);
          end else begin
            tx_level = tx_frame[0];
            tx_frame = tx_frame >> 1;
            tx_left = tx_left - 4'd1;
            tx_count = bit_period;
          end
        end
        if (rx_hunt) begin
          // a start needs a falling edge
          if (rx_prev && !line) begin
            rx_hunt = 1'b0;
            rx_count = first_sample_period;
            rx_index = '0;
            rx_shift = '0;
          end
        end else if (rx_count > 1) begin
          rx_count = rx_count - TIMER_W'(1);
        end else begin
          if (line && rx_index < DATA_BITS) rx_shift[rx_index[2:0]] = 1'b1;
          rx_index = rx_index + 4'd1;
          rx_count = bit_period;
          if (rx_index >= DATA_BITS) begin
            rx_hunt = 1'b1;
            // drop the byte when the FIFO is full
            if (received_bytes.size() < FIFO_DEPTH) received_bytes.push_back(rx_shift);
          end
        end
        rx_prev = line;
      end
      OP_WRITE: begin
        if (tx_left != 0) begin
          s.write_refused = 1'b1;
        end else begin
          tx_frame = {1'b1, data, 1'b0};
          tx_left = 4'(FRAME_BITS);
          tx_count = bit_period;
        end
      end
      OP_READ: begin
        if (received_bytes.size() == 0) s.read_empty = 1'b1;
        else s.read_data = received_bytes.pop_front();
      end
      default: ;
    endcase
    s.tx_line = tx_level;
    s.tx_busy = (tx_left != 0);
    s.rx_available = FIFO_CW'(received_bytes.size());
    return s;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s at result %0d: expected %0h, got %0h",
                 field, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin
    uart_status_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{tx_line, tx_busy, write_refused, read_data, read_empty, rx_available};
      if (awaited_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %0d arrived with none awaited", results_seen);
      end else begin
        want = awaited_status.pop_front();
        check_field("tx_line", want.tx_line, got.tx_line);
        check_field("tx_busy", want.tx_busy, got.tx_busy);
        check_field("write_refused", want.write_refused, got.write_refused);
        check_field("read_data", want.read_data, got.read_data);
        check_field("read_empty", want.read_empty, got.read_empty);
        check_field("rx_available", want.rx_available, got.rx_available);
      end
      results_seen++;
    end
  end

  // Receiver side: random stalls, or a long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic [1:0] op, logic [DATA_BITS-1:0] data, logic line);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    tx_byte <= data;
    rx_line <= line;
    do @(posedge clk); while (in_stall);
    awaited_status.push_back(advance_uart(op, data, line));
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic reg_index, logic [TIMER_W-1:0] value);
    logic [31:0] word;
    word = $urandom();
    word[TIMER_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_index == REG_BIT_TICKS) bit_period = (value == '0) ? TIMER_W'(1) : value;
    else first_sample_period = (value == '0) ? TIMER_W'(1) : value;
    // straight into a read-back of the same register
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field(reg_index == REG_BIT_TICKS ? "bit_ticks read-back" : "first_sample read-back",
                value, prdata[TIMER_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_other();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) send_item(OP_WRITE, 8'($urandom), 1'($urandom));
    else if (pick < 9) send_item(OP_READ, 8'($urandom), 1'($urandom));
    else send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
  endtask

  // Drive one frame on rx_line, data bits held across sample ticks but for glitches.
  task automatic send_rx_frame(logic [DATA_BITS-1:0] data, int mix_pct, int glitch_pct);
    int fs, bt, span, k;
    logic line;
    fs = int'(first_sample_period);
    bt = int'(bit_period);
    span = fs + DATA_BITS * bt + 1;
    send_item(OP_TICK, 8'($urandom), 1'b1);
    send_item(OP_TICK, 8'($urandom), 1'b0);
    for (int t = 1; t <= span; t++) begin
      if ($urandom_range(99) < mix_pct) send_other();
      if (t < fs) begin
        line = 1'b0;
      end else begin
        k = (t - fs) / bt;
        line = (k < DATA_BITS) ? data[k] : 1'b1;
      end
      if ($urandom_range(99) < glitch_pct) line = ~line;
      send_item(OP_TICK, 8'($urandom), line);
    end
  endtask

  task automatic test_reset_values();
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_UNUSED, 8'hFF, 1'b0);
    send_item(OP_TICK, 8'h00, 1'b1);
    send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    settle();
  endtask

  task automatic test_frame_loop();
    write_register(REG_BIT_TICKS, 16'd1);
    write_register(REG_FIRST_SAMPLE, 16'd1);
    send_item(OP_WRITE, 8'hFF, 1'b1);
    send_item(OP_WRITE, 8'h00, 1'b1);
    send_rx_frame(8'h00, 0, 0);
    send_item(OP_WRITE, 8'h5A, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic(int budget);
    int stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_rx_frame(8'($urandom), 15, 0);
      end else if (pick < 75) begin
        send_rx_frame(8'($urandom), 15, 8);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) send_item(OP_TICK, 8'($urandom), 1'($urandom));
          else send_other();
        end
      end
    end
    settle();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(50);
    idle_pct = 29;
    stall_pct = 29;
  endtask

  task automatic test_fifo_overflow();
    write_register(REG_BIT_TICKS, 16'd1);
    write_register(REG_FIRST_SAMPLE, 16'd2);
    // hold the result side so the input backs up
    hold_request = 1'b1;
    repeat (FIFO_DEPTH + 1) send_rx_frame(8'($urandom), 0, 0);
    repeat (FIFO_DEPTH + 2) send_item(OP_READ, 8'($urandom), 1'b1);
    settle();
  endtask

  task automatic test_long_periods();
    write_register(REG_BIT_TICKS, 16'hFFFF);
    write_register(REG_FIRST_SAMPLE, 16'hFFFF);
    send_item(OP_WRITE, 8'h3C, 1'b1);
    send_item(OP_TICK, 8'h00, 1'b1);
    send_item(OP_TICK, 8'h00, 1'b0);
    repeat (4) send_item(OP_TICK, 8'($urandom), 1'($urandom));
    send_item(OP_WRITE, 8'hC3, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    settle();
  endtask

  initial begin
    clear_uart_state();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    operation <= OP_TICK;
    tx_byte <= '0;
    rx_line <= 1'b1;
    out_stall <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_frame_loop();
    write_register(REG_BIT_TICKS, 16'd2);
    write_register(REG_FIRST_SAMPLE, 16'd3);
    test_random_traffic(40);
    write_register(REG_BIT_TICKS, 16'd0);
    write_register(REG_FIRST_SAMPLE, 16'd0);
    test_random_traffic(40);
    write_register(REG_BIT_TICKS, 16'd3);
    write_register(REG_FIRST_SAMPLE, 16'd1);
    test_random_traffic(40);
    write_register(REG_BIT_TICKS, TIMER_W'($urandom_range(1, 4)));
    write_register(REG_FIRST_SAMPLE, TIMER_W'($urandom_range(1, 8)));
    test_random_traffic(40);
    test_back_to_back();
    test_fifo_overflow();
    test_long_periods();

    settle();
    if (fail_count == 0 && awaited_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/tsu_pkg.sv
rtl/tsu_tx.sv
rtl/tsu_rx.sv
rtl/tsu_fifo.sv
rtl/timer_sampled_uart_with_rx_fifo_top.sv
bench/timer_sampled_uart_with_rx_fifo_top_tb.sv
